>>> rtl/des_pkg.sv
package des_pkg;

  localparam int KeyCount   = 3;
  localparam int Rounds     = 16;
  localparam int RkAddrW    = 6;
  localparam int RoundCntW  = 4;

  localparam logic [1:0] ModeSingle = 2'd0;
  localparam logic [1:0] ModeTwoKey = 2'd1;

  localparam logic [1:0] RegKeyOne   = 2'd0;
  localparam logic [1:0] RegKeyTwo   = 2'd1;
  localparam logic [1:0] RegKeyThree = 2'd2;
  localparam logic [1:0] RegMode     = 2'd3;

  typedef logic [7:0] tbl_t [64];

  localparam tbl_t IpTbl = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam tbl_t FpTbl = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [7:0] ETbl [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [7:0] PTbl [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

  localparam logic [7:0] Pc1Tbl [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};

  localparam logic [7:0] Pc2Tbl [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

  localparam logic [15:0] TwoStep = 16'b0111111011111100;

  localparam logic [3:0] SBox [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm64(input logic [63:0] x, input tbl_t t);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = x[64-t[i]];
    return o;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] k);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) o[55-i] = k[64-Pc1Tbl[i]];
    return o;
  endfunction

  function automatic logic [47:0] pc2(input logic [55:0] cd);
    logic [47:0] o;
    for (int i = 0; i < 48; i++) o[47-i] = cd[56-Pc2Tbl[i]];
    return o;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input logic two);
    return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [5:0]  six;
    logic [31:0] o;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-ETbl[i]];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      s[31-4*i -: 4] = SBox[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = s[32-PTbl[i]];
    return o;
  endfunction

endpackage

>>> rtl/des_key_sched.sv
// Round key generator: one round key per cycle into the round key memory.
module des_round_keygen (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  slot,
  input  logic [63:0] key,
  output logic        busy,
  output logic        wr_en,
  output logic [5:0]  wr_addr,
  output logic [47:0] wr_data
);
  logic        busy_r, busy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [27:0] c_r, c_nxt, d_r, d_nxt;
  logic [27:0] c_rot, d_rot;
  logic [55:0] cd0;

  assign cd0   = des_pkg::pc1(key);
  assign c_rot = des_pkg::rot28(c_r, des_pkg::TwoStep[cnt_r]);
  assign d_rot = des_pkg::rot28(d_r, des_pkg::TwoStep[cnt_r]);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      slot_nxt = slot;
      c_nxt    = cd0[55:28];
      d_nxt    = cd0[27:0];
    end else if (busy_r) begin
      c_nxt   = c_rot;
      d_nxt   = d_rot;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    slot_r <= slot_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
  end

  assign busy    = busy_r;
  assign wr_en   = busy_r;
  assign wr_addr = {slot_r, cnt_r};
  assign wr_data = des_pkg::pc2({c_rot, d_rot});
endmodule

>>> rtl/des_tdes_block_cipher.sv
// DES / triple DES (EDE) block cipher, ECB.
// Each DES pass is a load step (S_LOAD) followed by 16 rounds (S_ROUND); triple
// DES runs three passes before out_valid. One transaction at a time: a new
// transaction is accepted only after the last result has been taken.
// The shared round unit reads one round key per cycle from the 48x48 round
// key memory (one read port).
// Reset: keys and mode clear; the all-zero keys are expanded after reset,
// one key after another, while in_stall is high. A key write queues a
// re-expansion of that key, in_stall high meanwhile.
module des_tdes_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [63:0] in_block_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_block_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_DONE} state_t;

  state_t      state_r;
  logic [63:0] key1_r, key2_r, key3_r;
  logic [1:0]  mode_r;
  logic [2:0]  pend_r, pend_nxt;
  logic        op_r;
  logic [1:0]  pass_r;
  logic [3:0]  rnd_r;
  logic [31:0] l_r, r_r;
  logic        out_valid_r;
  logic [63:0] out_r;

  // round key memory, sync read
  logic [47:0] rk_mem [48];
  logic [47:0] rk_q_r;
  logic [5:0]  rd_addr;

  logic        wr_cfg;
  logic        key_wr;
  logic [1:0]  reg_idx;
  logic        ks_start, ks_busy, ks_we;
  logic [1:0]  ks_slot;
  logic [63:0] ks_key;
  logic [5:0]  ks_addr;
  logic [47:0] ks_data;

  assign pready  = 1'b1;
  assign wr_cfg  = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];
  assign key_wr  = wr_cfg && paddr[2:0] == 3'd0 && reg_idx != des_pkg::RegMode;

  always_comb begin
    case (reg_idx)
      des_pkg::RegKeyOne:   prdata = key1_r;
      des_pkg::RegKeyTwo:   prdata = key2_r;
      des_pkg::RegKeyThree: prdata = key3_r;
      default:              prdata = {62'd0, mode_r};
    endcase
  end

  // key expansion kick: one pending key slot at a time, lowest first.
  // A key written again during its own expansion stays pending and is redone.
  always_comb begin
    ks_start = !ks_busy && (pend_r != 3'd0);
    if (pend_r[0])      ks_slot = des_pkg::RegKeyOne;
    else if (pend_r[1]) ks_slot = des_pkg::RegKeyTwo;
    else                ks_slot = des_pkg::RegKeyThree;
    case (ks_slot)
      des_pkg::RegKeyOne: ks_key = key1_r;
      des_pkg::RegKeyTwo: ks_key = key2_r;
      default:            ks_key = key3_r;
    endcase
    pend_nxt = pend_r;
    if (ks_start) pend_nxt[ks_slot] = 1'b0;
    if (key_wr)   pend_nxt[reg_idx] = 1'b1;
  end

  des_round_keygen u_ks (
    .clk(clk), .rst_n(rst_n), .start(ks_start), .slot(ks_slot), .key(ks_key),
    .busy(ks_busy), .wr_en(ks_we), .wr_addr(ks_addr), .wr_data(ks_data)
  );

  // key slot for each pass
  logic [1:0] slot;
  logic       dec;
  always_comb begin
    dec  = op_r ^ pass_r[0];
    slot = 2'd0;
    if (mode_r == des_pkg::ModeSingle) slot = 2'd0;
    else if (pass_r == 2'd1) slot = 2'd1;
    else if (mode_r == des_pkg::ModeTwoKey) slot = 2'd0;
    else slot = (op_r ^ (pass_r == 2'd2)) ? 2'd2 : 2'd0;
  end
  logic [3:0] rnd_rd;
  assign rnd_rd  = (state_r == S_LOAD) ? 4'd0 : rnd_r + 4'd1;
  assign rd_addr = {slot, dec ? ~rnd_rd : rnd_rd};

  always_ff @(posedge clk) begin
    if (ks_we) rk_mem[ks_addr] <= ks_data;
    rk_q_r <= rk_mem[rd_addr];
  end

  logic [63:0] ipv, fin;
  logic [31:0] f_out;
  assign ipv   = des_pkg::perm64(in_block_in, des_pkg::IpTbl);
  assign f_out = des_pkg::feistel(r_r, rk_q_r);
  assign fin   = des_pkg::perm64({l_r ^ f_out, r_r}, des_pkg::FpTbl);

  // no accept while a key expansion is running or queued
  assign in_stall = (state_r != S_IDLE) || out_valid_r || ks_busy || (pend_r != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
      mode_r      <= '0;
      pend_r      <= 3'b111;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
      rnd_r       <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (wr_cfg && paddr[2:0] == 3'd0) begin
        case (reg_idx)
          des_pkg::RegKeyOne:   key1_r <= pwdata;
          des_pkg::RegKeyTwo:   key2_r <= pwdata;
          des_pkg::RegKeyThree: key3_r <= pwdata;
          default:              mode_r <= pwdata[1:0];
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r    <= in_op;
            l_r     <= ipv[63:32];
            r_r     <= ipv[31:0];
            pass_r  <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd_r == 4'd15) begin
            if (mode_r == des_pkg::ModeSingle || pass_r == 2'd2) begin
              out_r       <= fin;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              // FP then IP cancel: the halves go unswapped into the next pass
              l_r     <= l_r ^ f_out;
              r_r     <= r_r;
              pass_r  <= pass_r + 2'd1;
              state_r <= S_LOAD;
            end
          end else begin
            l_r   <= r_r;
            r_r   <= l_r ^ f_out;
            rnd_r <= rnd_r + 4'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_block_out = out_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> in_stall) else $error("accept during rounds");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("result dropped");
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_r != 2'd3)) else $error("pass overflow");
endmodule
